// ===== rtl/core/stc_pkg.sv =====
`default_nettype none

package stc_pkg;

    // configuration port
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned TARGET_W = 9;
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned NUM_TMR  = 3;

    // input field widths
    localparam int unsigned CYC_W    = 4;
    // cycle count after the widest slowdown shift
    localparam int unsigned SCYC_W   = CYC_W + (1 << SHIFT_W) - 1;

    // timer widths
    localparam int unsigned STAGE_W  = 8;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned TICKS_W  = 6;

    localparam logic [TARGET_W-1:0] TARGET_FULL = TARGET_W'(256);
    localparam logic [SHIFT_W-1:0]  SHIFT_RESET = SHIFT_W'(6);

    // register indexes
    typedef enum logic [2:0] {
        REG_ENABLES  = 3'd0,
        REG_TARGET0  = 3'd1,
        REG_TARGET1  = 3'd2,
        REG_TARGET2  = 3'd3,
        REG_SHIFT    = 3'd4
    } t_reg_idx;

    // request and response payloads
    typedef struct packed {
        logic [CYC_W-1:0] instr_cycles;
        logic             slowed;
    } t_req;

    typedef struct packed {
        logic [COUNT_W-1:0] count_zero;
        logic [COUNT_W-1:0] count_one;
        logic [COUNT_W-1:0] count_two;
        logic [TICKS_W-1:0] ticks_applied;
    } t_rsp;

    // configuration register file contents
    typedef struct packed {
        logic [NUM_TMR-1:0]  enables;
        logic [TARGET_W-1:0] target_zero;
        logic [TARGET_W-1:0] target_one;
        logic [TARGET_W-1:0] target_two;
        logic [SHIFT_W-1:0]  shift;
    } t_cfg;

    // microcode
    localparam int unsigned PC_W = 2;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_NO_REQ   = 2'd1,
        COND_TICK     = 2'd2,
        COND_OUT_BUSY = 2'd3
    } t_cond;

    typedef struct packed {
        logic            in_ready;
        logic            load;
        logic            tick;
        logic            push;
        t_cond           hold;
        logic [PC_W-1:0] next_pc;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic req_valid;
        logic tick_pending;
        logic out_busy;
    } t_stat;

    // datapath controls issued by the sequencer
    typedef struct packed {
        logic in_ready;
        logic load;
        logic tick;
        logic push;
    } t_ctrl;

    localparam logic [PC_W-1:0] PC_WAIT = PC_W'(0);
    localparam logic [PC_W-1:0] PC_LOOP = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SEND = PC_W'(2);

    // control store: wait for a request, tick until the residue is short, send
    function automatic t_uword rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{in_ready: 1'b0, load: 1'b0, tick: 1'b0, push: 1'b0,
              hold: COND_NONE, next_pc: PC_WAIT};
        case (pc)
            PC_WAIT: begin
                w.in_ready = 1'b1;
                w.load     = 1'b1;
                w.hold     = COND_NO_REQ;
                w.next_pc  = PC_LOOP;
            end
            PC_LOOP: begin
                w.tick     = 1'b1;
                w.hold     = COND_TICK;
                w.next_pc  = PC_SEND;
            end
            PC_SEND: begin
                w.push     = 1'b1;
                w.hold     = COND_OUT_BUSY;
                w.next_pc  = PC_WAIT;
            end
            default: begin
                w.next_pc  = PC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stc_stream_if.sv =====
`default_nettype none

interface stc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stc_regs.sv =====
`default_nettype none

module stc_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [stc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [stc_pkg::DATA_W-1:0]  pwdata,
    output logic      [stc_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output stc_pkg::t_cfg                    o_cfg
);

    stc_pkg::t_cfg    r_cfg;
    stc_pkg::t_cfg    n_cfg;
    stc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = stc_pkg::t_reg_idx'(paddr[stc_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                stc_pkg::REG_ENABLES: n_cfg.enables     = pwdata[stc_pkg::NUM_TMR-1:0];
                stc_pkg::REG_TARGET0: n_cfg.target_zero = pwdata[stc_pkg::TARGET_W-1:0];
                stc_pkg::REG_TARGET1: n_cfg.target_one  = pwdata[stc_pkg::TARGET_W-1:0];
                stc_pkg::REG_TARGET2: n_cfg.target_two  = pwdata[stc_pkg::TARGET_W-1:0];
                stc_pkg::REG_SHIFT:   n_cfg.shift       = pwdata[stc_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enables     <= '0;
            r_cfg.target_zero <= stc_pkg::TARGET_FULL;
            r_cfg.target_one  <= stc_pkg::TARGET_FULL;
            r_cfg.target_two  <= stc_pkg::TARGET_FULL;
            r_cfg.shift       <= stc_pkg::SHIFT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // register read mux
    always_comb begin
        case (w_idx)
            stc_pkg::REG_ENABLES: prdata = stc_pkg::DATA_W'(r_cfg.enables);
            stc_pkg::REG_TARGET0: prdata = stc_pkg::DATA_W'(r_cfg.target_zero);
            stc_pkg::REG_TARGET1: prdata = stc_pkg::DATA_W'(r_cfg.target_one);
            stc_pkg::REG_TARGET2: prdata = stc_pkg::DATA_W'(r_cfg.target_two);
            stc_pkg::REG_SHIFT:   prdata = stc_pkg::DATA_W'(r_cfg.shift);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/stc_timer.sv =====
`default_nettype none

module stc_timer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [stc_pkg::TARGET_W-1:0]  i_target,
    output logic      [stc_pkg::COUNT_W-1:0]   o_count
);

    logic [stc_pkg::STAGE_W-1:0]  r_stage;
    logic [stc_pkg::COUNT_W-1:0]  r_count;
    logic [stc_pkg::STAGE_W-1:0]  n_stage;
    logic [stc_pkg::COUNT_W-1:0]  n_count;
    logic [stc_pkg::TARGET_W-1:0] w_target;
    logic [stc_pkg::TARGET_W-1:0] w_next;

    // zero or anything past the full period acts as the full period
    assign w_target = (i_target == '0 || i_target > stc_pkg::TARGET_FULL)
                    ? stc_pkg::TARGET_FULL : i_target;
    assign w_next   = stc_pkg::TARGET_W'(r_stage) + stc_pkg::TARGET_W'(1);

    // stage counter wraps at the target and bumps the output counter
    always_comb begin
        n_stage = r_stage;
        n_count = r_count;
        if (i_step) begin
            if (w_next >= w_target) begin
                n_stage = '0;
                n_count = r_count + stc_pkg::COUNT_W'(1);
            end else begin
                n_stage = w_next[stc_pkg::STAGE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_count <= '0;
        end else begin
            r_stage <= n_stage;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/stc_seq.sv =====
`default_nettype none

module stc_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  stc_pkg::t_stat      i_stat,
    output stc_pkg::t_ctrl      o_ctrl
);

    logic [stc_pkg::PC_W-1:0] r_pc;
    logic [stc_pkg::PC_W-1:0] n_pc;
    stc_pkg::t_uword          w_word;
    logic                     w_hold;

    assign w_word = stc_pkg::rom(r_pc);

    // hold condition of the current step
    always_comb begin
        case (w_word.hold)
            stc_pkg::COND_NO_REQ:   w_hold = !i_stat.req_valid;
            stc_pkg::COND_TICK:     w_hold = i_stat.tick_pending;
            stc_pkg::COND_OUT_BUSY: w_hold = i_stat.out_busy;
            default:                w_hold = 1'b0;
        endcase
    end

    // step counter
    assign n_pc = w_hold ? r_pc : w_word.next_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= stc_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // control word gated by the step's condition
    always_comb begin
        o_ctrl.in_ready = w_word.in_ready;
        o_ctrl.load     = w_word.load && i_stat.req_valid;
        o_ctrl.tick     = w_word.tick && i_stat.tick_pending;
        o_ctrl.push     = w_word.push && !i_stat.out_busy;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sound_cpu_interval_timers_core.sv =====
`default_nettype none

// channel   dir  payload                                          request moves on
// i_req     in   instr_cycles, slowed                             valid && ready
// o_rsp     out  count_zero, count_one, count_two, ticks_applied  valid && ready
// apb cfg   in   five registers at 4*index                        psel && penable && pwrite
//
// an instruction: the wait step takes the request, the tick loop makes its fast
// ticks, the loop is left once the residue is short, and the send step loads the
// response register
// a new request is taken while the previous response still waits in o_rsp
// a full response register holds the sequencer in its send step
// synchronous active-low reset; counters, residue and prescaler clear to zero
module sound_cpu_interval_timers_core #(
    parameter int unsigned TICK_CYCLES = 32,
    parameter int unsigned SLOW_DIVIDE = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    stc_stream_if.sink                        i_req,
    stc_stream_if.source                      o_rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [stc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [stc_pkg::DATA_W-1:0]   pwdata,
    output logic      [stc_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int unsigned RES_W = (TICK_CYCLES > 2) ? $clog2(TICK_CYCLES) : 1;
    localparam int unsigned ACC_W = $clog2(TICK_CYCLES + (1 << stc_pkg::SCYC_W));
    localparam int unsigned PRE_W = $clog2(SLOW_DIVIDE);

    stc_pkg::t_cfg  w_cfg;
    stc_pkg::t_stat w_stat;
    stc_pkg::t_ctrl w_ctrl;
    stc_pkg::t_req  w_req;

    logic [RES_W-1:0]            r_residue;
    logic [ACC_W-1:0]            r_acc;
    logic [ACC_W-1:0]            n_acc;
    logic [PRE_W-1:0]            r_pre;
    logic [stc_pkg::TICKS_W-1:0] r_ticks;
    logic [stc_pkg::SCYC_W-1:0]  w_cycles;
    logic                        w_slow_tick;
    logic [stc_pkg::NUM_TMR-1:0] w_step;
    logic [stc_pkg::COUNT_W-1:0] w_count [stc_pkg::NUM_TMR];
    logic                        r_out_valid;
    stc_pkg::t_rsp               r_out;

    stc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    stc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    assign w_req       = i_req.payload;
    assign i_req.ready = w_ctrl.in_ready;

    // status back to the sequencer
    assign w_stat.req_valid    = i_req.valid;
    assign w_stat.tick_pending = (r_acc >= ACC_W'(TICK_CYCLES));
    assign w_stat.out_busy     = r_out_valid && !o_rsp.ready;

    // scaled cycle count of the instruction
    assign w_cycles = w_req.slowed
                    ? (stc_pkg::SCYC_W'(w_req.instr_cycles) << w_cfg.shift)
                    : stc_pkg::SCYC_W'(w_req.instr_cycles);

    // cycle accumulator: load residue plus cycles, take one tick's worth per step
    always_comb begin
        n_acc = r_acc;
        if (w_ctrl.load) begin
            n_acc = ACC_W'(r_residue) + ACC_W'(w_cycles);
        end else if (w_ctrl.tick) begin
            n_acc = r_acc - ACC_W'(TICK_CYCLES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_residue <= '0;
            r_pre     <= '0;
            r_ticks   <= '0;
        end else begin
            r_acc <= n_acc;
            if (w_ctrl.load) begin
                r_ticks <= '0;
            end else if (w_ctrl.tick) begin
                r_ticks <= r_ticks + stc_pkg::TICKS_W'(1);
            end
            if (w_ctrl.tick) begin
                r_pre <= w_slow_tick ? '0 : r_pre + PRE_W'(1);
            end
            if (w_ctrl.push) begin
                r_residue <= r_acc[RES_W-1:0];
            end
        end
    end

    // slow tick prescaler
    assign w_slow_tick = (r_pre == PRE_W'(SLOW_DIVIDE - 1));

    assign w_step[0] = w_ctrl.tick && w_slow_tick && w_cfg.enables[0];
    assign w_step[1] = w_ctrl.tick && w_slow_tick && w_cfg.enables[1];
    assign w_step[2] = w_ctrl.tick && w_cfg.enables[2];

    stc_timer u_timer0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step[0]),
        .i_target (w_cfg.target_zero),
        .o_count  (w_count[0])
    );

    stc_timer u_timer1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step[1]),
        .i_target (w_cfg.target_one),
        .o_count  (w_count[1])
    );

    stc_timer u_timer2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step[2]),
        .i_target (w_cfg.target_two),
        .o_count  (w_count[2])
    );

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.push) begin
            r_out.count_zero    <= w_count[0];
            r_out.count_one     <= w_count[1];
            r_out.count_two     <= w_count[2];
            r_out.ticks_applied <= r_ticks;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

`default_nettype wire
